@@ hdl/plar_pkg.sv @@
// shared types, constants and the arctangent table of the arc length resampler
`timescale 1ns / 1ps
package plar_pkg;

  localparam int FifoDepth = 2;

  localparam logic [1:0] KIND_CONTINUE = 2'd0;
  localparam logic [1:0] KIND_POLYLINE = 2'd1;
  localparam logic [1:0] KIND_PATH     = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'b01,
    OP_SEG   = 2'b10
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       not_empty;
    logic [1:0] count;
  } fifo_stat_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/plar_if.sv @@
// channel interfaces of the arc length resampler
`timescale 1ns / 1ps
interface plar_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  modport source(output valid, kind, point_x, point_y, input ready);
  modport sink(input valid, kind, point_x, point_y, output ready);
endinterface

interface plar_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  logic signed [15:0] heading;
  logic               last_anchor;
  logic               overflow;
  modport source(output valid, anchor_x, anchor_y, heading, last_anchor, overflow,
                 input ready);
  modport sink(input valid, anchor_x, anchor_y, heading, last_anchor, overflow,
               output ready);
endinterface

interface plar_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] step_length;
  modport source(output valid, step_length, input ready);
  modport sink(input valid, step_length, output ready);
endinterface

@@ hdl/plar_front.sv @@
// front end: accepts vertices, tracks the previous vertex and queues segment and clear jobs
`timescale 1ns / 1ps
module plar_front (
  input  logic                clk,
  input  logic                rst_n,
  plar_in_if.sink             in_ch,
  input  plar_pkg::fifo_stat_t stat,
  output logic                push,
  output plar_pkg::job_t      push_job
);
  import plar_pkg::*;

  logic               have_prev_r;
  logic signed [31:0] prev_x_r;
  logic signed [31:0] prev_y_r;
  logic               accept;
  logic               start_item;

  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start_item  = (in_ch.kind != KIND_CONTINUE) || !have_prev_r;

  always_comb begin
    push_job.op     = start_item ? OP_CLEAR : OP_SEG;
    push_job.base_x = prev_x_r;
    push_job.base_y = prev_y_r;
    push_job.dx     = $signed({in_ch.point_x[31], in_ch.point_x}) -
                      $signed({prev_x_r[31], prev_x_r});
    push_job.dy     = $signed({in_ch.point_y[31], in_ch.point_y}) -
                      $signed({prev_y_r[31], prev_y_r});
    push            = accept && (!start_item || in_ch.kind[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else if (accept) begin
      have_prev_r <= 1'b1;
      prev_x_r    <= in_ch.point_x;
      prev_y_r    <= in_ch.point_y;
    end
  end

endmodule

@@ hdl/plar_fifo.sv @@
// two-entry job queue between front and back end
`timescale 1ns / 1ps
module plar_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  plar_pkg::job_t       push_job,
  input  logic                 pop,
  output plar_pkg::job_t       head,
  output plar_pkg::fifo_stat_t stat
);
  import plar_pkg::*;

  job_t       mem_r [FifoDepth];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign head           = mem_r[rd_ptr_r];
  assign stat.full      = (cnt_r == 2'(FifoDepth));
  assign stat.not_empty = (cnt_r != 2'd0);
  assign stat.count     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/plar_muldiv.sv @@
// sequential multiply then divide: a*b/c, rounded when rnd is set, by shift-add and restoring division
`timescale 1ns / 1ps
module plar_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        rnd,
  input  logic [34:0] a,
  input  logic [32:0] b,
  input  logic [33:0] c,
  output logic        done,
  output logic [67:0] q,
  output logic [34:0] rem
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_RND  = 4'b1000
  } md_state_t;

  md_state_t   state_r;
  logic [6:0]  cnt_r;
  logic [67:0] acc_r;
  logic [67:0] a_sh_r;
  logic [32:0] b_sh_r;
  logic [34:0] rem_r;
  logic [67:0] q_r;
  logic [33:0] c_r;
  logic        rnd_r;
  logic        done_r;
  logic [34:0] rem_t;
  logic        fit;
  logic [34:0] half_gap;

  assign rem_t    = {rem_r[33:0], acc_r[67]};
  assign fit      = rem_t >= {1'b0, c_r};
  assign half_gap = {1'b0, c_r} - rem_r;
  assign done     = done_r;
  assign q        = q_r;
  assign rem      = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= {33'd0, a};
      b_sh_r <= b;
      c_r    <= c;
      rnd_r  <= rnd;
      q_r    <= '0;
    end else begin
      unique case (state_r)
        MD_MUL: begin
          if (b_sh_r[0]) acc_r <= acc_r + a_sh_r;
          a_sh_r <= {a_sh_r[66:0], 1'b0};
          b_sh_r <= {1'b0, b_sh_r[32:1]};
          rem_r  <= '0;
        end
        MD_DIV: begin
          acc_r <= {acc_r[66:0], 1'b0};
          q_r   <= {q_r[66:0], fit};
          rem_r <= fit ? rem_t - {1'b0, c_r} : rem_t;
        end
        MD_RND: begin
          if (rnd_r && (rem_r >= half_gap)) q_r <= q_r + 68'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        state_r <= MD_MUL;
        cnt_r   <= '0;
      end else begin
        unique case (state_r)
          MD_IDLE: begin
          end
          MD_MUL: begin
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'd32) begin
              state_r <= MD_DIV;
              cnt_r   <= '0;
            end
          end
          MD_DIV: begin
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'd67) state_r <= MD_RND;
          end
          MD_RND: begin
            state_r <= MD_IDLE;
            done_r  <= 1'b1;
          end
          default: state_r <= MD_IDLE;
        endcase
      end
    end
  end

endmodule

@@ hdl/plar_back.sv @@
// back end: segment length, heading, anchor spacing and anchor placement
`timescale 1ns / 1ps
module plar_back #(
  parameter int MAX_ANCHORS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  plar_pkg::job_t job,
  input  logic           job_valid,
  output logic           pop,
  input  logic [30:0]    step_length,
  plar_out_if.source     out_ch
);
  import plar_pkg::*;

  localparam int KW = $clog2(MAX_ANCHORS + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LOAD  = 12'b000000000010,
    S_SQ    = 12'b000000000100,
    S_SQRT  = 12'b000000001000,
    S_CPREP = 12'b000000010000,
    S_NORM  = 12'b000000100000,
    S_CORD  = 12'b000001000000,
    S_PLAN  = 12'b000010000000,
    S_DIV   = 12'b000100000000,
    S_AST   = 12'b001000000000,
    S_AMUL  = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t             state_r;
  logic signed [31:0] bx_r, by_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [32:0] carry_r;
  logic [33:0]        len_r;
  logic [67:0]        rad_r;
  logic [37:0]        sq_rem_r;
  logic [33:0]        root_r;
  logic [5:0]         it_r;
  logic signed [42:0] cx_r, cy_r;
  logic [39:0]        m_r;
  logic [31:0]        ang_r;
  logic [34:0]        s_r;
  logic [KW-1:0]      k_r;
  logic [KW-1:0]      last_k_r;
  logic               ovf_r;
  logic signed [31:0] ax_r, ay_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic signed [15:0] out_hd_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic [32:0]        adx, ady;
  logic [30:0]        rstep;
  logic signed [34:0] r35, a0_raw, a0, len35, span, span_m1;
  logic               rpos, skip;
  logic [37:0]        sq_t, sq_trial;
  logic               sq_fit;
  logic signed [42:0] xs, ys;
  logic [31:0]        ang_rnd;
  logic               out_free;
  logic [34:0]        rem_inc;

  logic               x_start, y_start, md_rnd;
  logic [34:0]        x_a, y_a;
  logic [32:0]        x_b, y_b;
  logic [33:0]        x_c, y_c;
  logic               x_done, y_done;
  logic [67:0]        x_q, y_q;
  logic [34:0]        x_rem;

  always_comb begin
    adx      = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    ady      = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    rstep    = (step_length == '0) ? 31'd1 : step_length;
    r35      = {{2{carry_r[32]}}, carry_r};
    rpos     = !carry_r[32] && (carry_r != '0);
    a0_raw   = rpos ? $signed({4'd0, rstep}) - r35 : -r35;
    a0       = a0_raw[34] ? '0 : a0_raw;
    len35    = $signed({1'b0, len_r});
    skip     = (carry_r != '0) && (a0 >= len35);
    span     = len35 - a0;
    span_m1  = span - 35'sd1;
    sq_t     = {sq_rem_r[35:0], rad_r[67:66]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_fit   = sq_t >= sq_trial;
    xs       = cx_r >>> it_r;
    ys       = cy_r >>> it_r;
    ang_rnd  = ang_r + 32'h0000_8000;
    out_free = !out_valid_r || out_ch.ready;
    rem_inc  = x_rem + 35'd1;
  end

  always_comb begin
    x_start = 1'b0;
    y_start = 1'b0;
    md_rnd  = (state_r == S_AST);
    x_a     = s_r;
    x_b     = adx;
    x_c     = len_r;
    y_a     = s_r;
    y_b     = ady;
    y_c     = len_r;
    unique case (state_r)
      S_LOAD: begin
        x_start = 1'b1;
        y_start = 1'b1;
        x_a     = {2'b00, adx};
        x_c     = 34'd1;
        y_a     = {2'b00, ady};
        y_c     = 34'd1;
      end
      S_PLAN: begin
        x_start = !skip && (span != '0);
        x_a     = 35'(span_m1);
        x_b     = 33'd1;
        x_c     = {3'b000, rstep};
      end
      S_AST: begin
        x_start = (len_r != '0);
        y_start = (len_r != '0);
      end
      default: begin
      end
    endcase
  end

  plar_muldiv u_md_x (
    .clk(clk), .rst_n(rst_n), .start(x_start), .rnd(md_rnd),
    .a(x_a), .b(x_b), .c(x_c), .done(x_done), .q(x_q), .rem(x_rem)
  );

  plar_muldiv u_md_y (
    .clk(clk), .rst_n(rst_n), .start(y_start), .rnd(md_rnd),
    .a(y_a), .b(y_b), .c(y_c), .done(y_done), .q(y_q), .rem()
  );

  assign pop = (state_r == S_IDLE) && job_valid;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          bx_r <= job.base_x;
          by_r <= job.base_y;
          dx_r <= job.dx;
          dy_r <= job.dy;
        end
      end
      S_SQ: begin
        rad_r    <= x_q + y_q;
        sq_rem_r <= '0;
        root_r   <= '0;
        it_r     <= '0;
      end
      S_SQRT: begin
        rad_r    <= {rad_r[65:0], 2'b00};
        sq_rem_r <= sq_fit ? sq_t - sq_trial : sq_t;
        root_r   <= {root_r[32:0], sq_fit};
        it_r     <= it_r + 6'd1;
      end
      S_CPREP: begin
        len_r <= root_r + 34'(sq_rem_r > {4'd0, root_r});
        cx_r  <= dx_r[32] ? -43'(dx_r) : 43'(dx_r);
        cy_r  <= dx_r[32] ? -43'(dy_r) : 43'(dy_r);
        m_r   <= (adx > ady) ? {7'd0, adx} : {7'd0, ady};
        ang_r <= dx_r[32] ? 32'h8000_0000 : 32'h0;
        it_r  <= '0;
      end
      S_NORM: begin
        if (!m_r[39]) begin
          m_r  <= {m_r[38:0], 1'b0};
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
        end
      end
      S_CORD: begin
        it_r <= it_r + 6'd1;
        if (!cy_r[42]) begin
          cx_r  <= cx_r + ys;
          cy_r  <= cy_r - xs;
          ang_r <= ang_r + atan_lut(it_r[4:0]);
        end else begin
          cx_r  <= cx_r - ys;
          cy_r  <= cy_r + xs;
          ang_r <= ang_r - atan_lut(it_r[4:0]);
        end
      end
      S_PLAN: begin
        s_r      <= 35'(a0);
        k_r      <= '0;
        last_k_r <= '0;
        ovf_r    <= 1'b0;
      end
      S_DIV: begin
        if (x_done) begin
          ovf_r    <= x_q >= 68'(MAX_ANCHORS);
          last_k_r <= (x_q >= 68'(MAX_ANCHORS)) ? KW'(MAX_ANCHORS - 1) : x_q[KW-1:0];
        end
      end
      S_AST: begin
        if (len_r == '0) begin
          ax_r <= bx_r;
          ay_r <= by_r;
        end
      end
      S_AMUL: begin
        if (x_done && y_done) begin
          ax_r <= bx_r + (dx_r[32] ? -x_q[31:0] : x_q[31:0]);
          ay_r <= by_r + (dy_r[32] ? -y_q[31:0] : y_q[31:0]);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          k_r <= k_r + KW'(1);
          s_r <= s_r + {4'd0, rstep};
        end
      end
      default: begin
      end
    endcase
    if (state_r == S_CPREP && dx_r == '0 && dy_r == '0) ang_r <= '0;
  end

  // control and carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      carry_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            if (job.op == OP_CLEAR) carry_r <= '0;
            else state_r <= S_LOAD;
          end
        end
        S_LOAD: state_r <= S_SQ;
        S_SQ:   if (x_done && y_done) state_r <= S_SQRT;
        S_SQRT: if (it_r == 6'd33) state_r <= S_CPREP;
        S_CPREP: begin
          if (dx_r == '0 && dy_r == '0) state_r <= S_PLAN;
          else state_r <= S_NORM;
        end
        S_NORM: if (m_r[39]) state_r <= S_CORD;
        S_CORD: if (it_r == 6'd23) state_r <= S_PLAN;
        S_PLAN: begin
          if (skip) begin
            carry_r <= (a0 == len35) ? '0 : 33'(len35 - a0);
            state_r <= S_IDLE;
          end else if (span == '0) begin
            carry_r <= '0;
            state_r <= S_AST;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (x_done) begin
            carry_r <= (rem_inc == {4'd0, rstep}) ? '0 : 33'(rem_inc);
            state_r <= S_AST;
          end
        end
        S_AST: state_r <= (len_r == '0) ? S_EMIT : S_AMUL;
        S_AMUL: if (x_done && y_done) state_r <= S_EMIT;
        S_EMIT: begin
          if (out_free) state_r <= (k_r == last_k_r) ? S_IDLE : S_AST;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_x_r    <= ax_r;
      out_y_r    <= ay_r;
      out_hd_r   <= ang_rnd[31:16];
      out_last_r <= (k_r == last_k_r);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.anchor_x    = out_x_r;
  assign out_ch.anchor_y    = out_y_r;
  assign out_ch.heading     = out_hd_r;
  assign out_ch.last_anchor = out_last_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

@@ hdl/polyline_arc_length_resampler.sv @@
// Polyline arc length resampler top level. Vertices enter on in_ch; each vertex that
// continues a polyline closes a segment, and anchors (x, y, heading) spaced step_length
// apart along the path leave on out_ch, last_anchor marking the final one of a segment.
// A two-entry queue decouples vertex intake from the segment engine. Per segment the
// engine computes the squared components, the square root, normalizes, runs the CORDIC
// heading and the anchor count division, then places each anchor in the shared
// multiply-divide units. Vertices that start a polyline or path run no segment
// computation. The user must write step_length on cfg_ch only while the block is idle;
// the block does not enforce this. At most MAX_ANCHORS_PER_SEGMENT anchors per segment.
`timescale 1ns / 1ps
module polyline_arc_length_resampler #(
  parameter int MAX_ANCHORS_PER_SEGMENT = 64
) (
  input logic         clk,
  input logic         rst_n,
  plar_in_if.sink     in_ch,
  plar_out_if.source  out_ch,
  plar_cfg_if.sink    cfg_ch
);
  import plar_pkg::*;

  logic [30:0] step_length_r;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head;
  fifo_stat_t  stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) step_length_r <= 31'd65536;
    else if (cfg_ch.valid) step_length_r <= cfg_ch.step_length;
  end

  plar_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .stat(stat),
    .push(push), .push_job(push_job)
  );

  plar_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job),
    .pop(pop), .head(head), .stat(stat)
  );

  plar_back #(
    .MAX_ANCHORS(MAX_ANCHORS_PER_SEGMENT)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .job(head), .job_valid(stat.not_empty),
    .pop(pop), .step_length(step_length_r), .out_ch(out_ch)
  );

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= 2'(FifoDepth))
    else $error("job queue count beyond depth");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_ch.valid && in_ch.ready))
    else $error("job pushed without input transaction");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("job pushed into full queue");
`endif

endmodule
